// ===== sv/sdr_pkg.sv =====
`timescale 1ns / 1ps

package sdr_pkg;

    // Queue between decode and execution
    localparam int unsigned QUEUE_DEPTH = 2;

    // Input actions
    localparam logic [2:0] ACT_REQUEST  = 3'd0;
    localparam logic [2:0] ACT_BUS_MSG  = 3'd1;
    localparam logic [2:0] ACT_COMM_ERR = 3'd2;
    localparam logic [2:0] ACT_SLV_MSG  = 3'd3;
    localparam logic [2:0] ACT_OVERRUN  = 3'd4;
    localparam logic [2:0] ACT_RESULT   = 3'd5;
    localparam logic [2:0] ACT_RESET    = 3'd6;

    // Event log commands
    localparam logic [2:0] EVA_NONE      = 3'd0;
    localparam logic [2:0] EVA_PUSH      = 3'd1;
    localparam logic [2:0] EVA_RESTART   = 3'd2;
    localparam logic [2:0] EVA_RESTART_C = 3'd3;
    localparam logic [2:0] EVA_CLR_CNT   = 3'd4;

    // Protocol constants
    localparam logic [7:0]  FC_DIAG       = 8'h08;
    localparam logic [7:0]  FC_DIAG_EXC   = 8'h88;
    localparam logic [7:0]  EXC_ILL_FUNC  = 8'h01;
    localparam logic [7:0]  EXC_ILL_VALUE = 8'h03;
    localparam logic [7:0]  EV_RX_COMM    = 8'h82;
    localparam logic [7:0]  EV_RX_OVR     = 8'h92;
    localparam logic [7:0]  EV_LISTEN     = 8'h20;
    localparam logic [7:0]  EV_ENTER_LO   = 8'h04;
    localparam logic [15:0] STOP_ON_ERROR = 16'hFF00;
    localparam logic [2:0]  LEN_NONE      = 3'd0;
    localparam logic [2:0]  LEN_EXC       = 3'd2;
    localparam logic [2:0]  LEN_NORMAL    = 3'd5;

    // Sub-function codes
    localparam logic [15:0] SF_ECHO     = 16'h0000;
    localparam logic [15:0] SF_RESTART  = 16'h0001;
    localparam logic [15:0] SF_DIAG_REG = 16'h0002;
    localparam logic [15:0] SF_DELIM    = 16'h0003;
    localparam logic [15:0] SF_LISTEN   = 16'h0004;
    localparam logic [15:0] SF_CLEAR    = 16'h000A;
    localparam logic [15:0] SF_BUS_CNT  = 16'h000B;
    localparam logic [15:0] SF_COMM_CNT = 16'h000C;
    localparam logic [15:0] SF_EXC_CNT  = 16'h000D;
    localparam logic [15:0] SF_SLV_CNT  = 16'h000E;
    localparam logic [15:0] SF_NR_CNT   = 16'h000F;
    localparam logic [15:0] SF_NAK_CNT  = 16'h0010;
    localparam logic [15:0] SF_BUSY_CNT = 16'h0011;
    localparam logic [15:0] SF_OVR_CNT  = 16'h0012;
    localparam logic [15:0] SF_CLR_OVR  = 16'h0014;

    typedef enum logic [3:0] {
        CLS_ECHO,
        CLS_RESTART,
        CLS_DIAG_REG,
        CLS_LISTEN,
        CLS_CLEAR,
        CLS_READ,
        CLS_CLR_OVR,
        CLS_UNKNOWN
    } t_req_class;

    typedef enum logic [2:0] {
        CNT_BUS,
        CNT_COMM,
        CNT_EXC,
        CNT_SLAVE,
        CNT_NORESP,
        CNT_OVR,
        CNT_ZERO
    } t_cnt_sel;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  request_fc;
        logic        short_request;
        logic [15:0] sub_func;
        logic [15:0] data_word;
        logic        broadcast;
        logic        responded;
        logic        was_exception;
    } t_in;

    typedef struct packed {
        logic [2:0] resp_len;
        logic [7:0] resp_byte0;
        logic [7:0] resp_byte1;
        logic [7:0] resp_byte2;
        logic [7:0] resp_byte3;
        logic [7:0] resp_byte4;
        logic [2:0] event_action;
        logic [7:0] event_code;
        logic       listen_only_now;
    } t_out;

    // Classified item handed from decode to execution
    typedef struct packed {
        logic [2:0]  action;
        t_req_class  cls;
        t_cnt_sel    cnt_sel;
        logic        data_ok;
        logic        stop_on_err;
        logic        bc_allowed;
        logic        short_req;
        logic        bc;
        logic [7:0]  fc;
        logic [15:0] sf;
        logic [15:0] data;
        logic        responded;
        logic        was_exc;
    } t_cmd;

endpackage

// ===== sv/sdr_front.sv =====
`timescale 1ns / 1ps

module sdr_front (
    input  sdr_pkg::t_in  i_item,
    output sdr_pkg::t_cmd o_cmd
);

    logic data_zero;
    logic data_stop;

    assign data_zero = (i_item.data_word == 16'h0000);
    assign data_stop = (i_item.data_word == sdr_pkg::STOP_ON_ERROR);

    always_comb begin
        o_cmd             = '0;
        o_cmd.action      = i_item.action;
        o_cmd.short_req   = i_item.short_request;
        o_cmd.bc          = i_item.broadcast;
        o_cmd.fc          = i_item.request_fc;
        o_cmd.sf          = i_item.sub_func;
        o_cmd.data        = i_item.data_word;
        o_cmd.responded   = i_item.responded;
        o_cmd.was_exc     = i_item.was_exception;
        o_cmd.stop_on_err = data_stop;
        o_cmd.data_ok     = data_zero;
        o_cmd.cnt_sel     = sdr_pkg::CNT_ZERO;
        o_cmd.bc_allowed  = 1'b0;
        o_cmd.cls         = sdr_pkg::CLS_UNKNOWN;
        case (i_item.sub_func)
            sdr_pkg::SF_ECHO, sdr_pkg::SF_DELIM: begin
                // any data word is echoed back
                o_cmd.cls     = sdr_pkg::CLS_ECHO;
                o_cmd.data_ok = 1'b1;
            end
            sdr_pkg::SF_RESTART: begin
                o_cmd.cls        = sdr_pkg::CLS_RESTART;
                o_cmd.data_ok    = data_zero | data_stop;
                o_cmd.bc_allowed = 1'b1;
            end
            sdr_pkg::SF_DIAG_REG: begin
                o_cmd.cls = sdr_pkg::CLS_DIAG_REG;
            end
            sdr_pkg::SF_LISTEN: begin
                o_cmd.cls        = sdr_pkg::CLS_LISTEN;
                o_cmd.bc_allowed = 1'b1;
            end
            sdr_pkg::SF_CLEAR: begin
                o_cmd.cls        = sdr_pkg::CLS_CLEAR;
                o_cmd.bc_allowed = 1'b1;
            end
            sdr_pkg::SF_BUS_CNT: begin
                o_cmd.cls     = sdr_pkg::CLS_READ;
                o_cmd.cnt_sel = sdr_pkg::CNT_BUS;
            end
            sdr_pkg::SF_COMM_CNT: begin
                o_cmd.cls     = sdr_pkg::CLS_READ;
                o_cmd.cnt_sel = sdr_pkg::CNT_COMM;
            end
            sdr_pkg::SF_EXC_CNT: begin
                o_cmd.cls     = sdr_pkg::CLS_READ;
                o_cmd.cnt_sel = sdr_pkg::CNT_EXC;
            end
            sdr_pkg::SF_SLV_CNT: begin
                o_cmd.cls     = sdr_pkg::CLS_READ;
                o_cmd.cnt_sel = sdr_pkg::CNT_SLAVE;
            end
            sdr_pkg::SF_NR_CNT: begin
                o_cmd.cls     = sdr_pkg::CLS_READ;
                o_cmd.cnt_sel = sdr_pkg::CNT_NORESP;
            end
            sdr_pkg::SF_NAK_CNT, sdr_pkg::SF_BUSY_CNT: begin
                o_cmd.cls = sdr_pkg::CLS_READ;
            end
            sdr_pkg::SF_OVR_CNT: begin
                o_cmd.cls     = sdr_pkg::CLS_READ;
                o_cmd.cnt_sel = sdr_pkg::CNT_OVR;
            end
            sdr_pkg::SF_CLR_OVR: begin
                o_cmd.cls = sdr_pkg::CLS_CLR_OVR;
            end
            default: begin
                o_cmd.cls = sdr_pkg::CLS_UNKNOWN;
            end
        endcase
    end

endmodule

// ===== sv/sdr_queue.sv =====
`timescale 1ns / 1ps

module sdr_queue #(
    parameter int unsigned DEPTH = sdr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sdr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output sdr_pkg::t_cmd o_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sdr_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/sdr_back.sv =====
`timescale 1ns / 1ps

module sdr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  sdr_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output sdr_pkg::t_out o_item
);

    logic [15:0]   r_bus_cnt, n_bus_cnt;
    logic [15:0]   r_comm_cnt, n_comm_cnt;
    logic [15:0]   r_exc_cnt, n_exc_cnt;
    logic [15:0]   r_slv_cnt, n_slv_cnt;
    logic [15:0]   r_nr_cnt, n_nr_cnt;
    logic [15:0]   r_ovr_cnt, n_ovr_cnt;
    logic          r_listen, n_listen;
    logic          r_out_valid;
    sdr_pkg::t_out r_out, n_out;

    logic          put_five;
    logic          put_exc;
    logic          use_fc;
    logic [7:0]    exc_code;
    logic [15:0]   value;
    logic [15:0]   cnt_value;
    logic          clear_all;
    logic [7:0]    lo_mark;

    // Take an item whenever the output register is free or being emptied
    assign o_cmd_pop = i_cmd_valid & (~r_out_valid | i_ready);
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;
    assign lo_mark   = r_listen ? sdr_pkg::EV_LISTEN : 8'h00;

    always_comb begin
        case (i_cmd.cnt_sel)
            sdr_pkg::CNT_BUS:    cnt_value = r_bus_cnt;
            sdr_pkg::CNT_COMM:   cnt_value = r_comm_cnt;
            sdr_pkg::CNT_EXC:    cnt_value = r_exc_cnt;
            sdr_pkg::CNT_SLAVE:  cnt_value = r_slv_cnt;
            sdr_pkg::CNT_NORESP: cnt_value = r_nr_cnt;
            sdr_pkg::CNT_OVR:    cnt_value = r_ovr_cnt;
            default:             cnt_value = 16'h0000;
        endcase
    end

    always_comb begin
        n_bus_cnt  = r_bus_cnt;
        n_comm_cnt = r_comm_cnt;
        n_exc_cnt  = r_exc_cnt;
        n_slv_cnt  = r_slv_cnt;
        n_nr_cnt   = r_nr_cnt;
        n_ovr_cnt  = r_ovr_cnt;
        n_listen   = r_listen;
        n_out      = '0;
        put_five   = 1'b0;
        put_exc    = 1'b0;
        use_fc     = 1'b1;
        exc_code   = sdr_pkg::EXC_ILL_VALUE;
        value      = i_cmd.data;
        clear_all  = 1'b0;

        case (i_cmd.action)
            sdr_pkg::ACT_REQUEST: begin
                if (i_cmd.short_req) begin
                    put_exc = ~r_listen;
                end else if (r_listen && i_cmd.cls != sdr_pkg::CLS_RESTART) begin
                    put_exc = 1'b0;
                end else if (i_cmd.bc && !i_cmd.bc_allowed) begin
                    put_exc = 1'b0;
                end else if (i_cmd.cls == sdr_pkg::CLS_UNKNOWN) begin
                    put_exc  = 1'b1;
                    exc_code = sdr_pkg::EXC_ILL_FUNC;
                end else if (!i_cmd.data_ok) begin
                    put_exc = 1'b1;
                end else begin
                    case (i_cmd.cls)
                        sdr_pkg::CLS_ECHO: begin
                            put_five = 1'b1;
                        end
                        sdr_pkg::CLS_RESTART: begin
                            clear_all          = 1'b1;
                            n_out.event_action = i_cmd.stop_on_err ?
                                                 sdr_pkg::EVA_RESTART_C :
                                                 sdr_pkg::EVA_RESTART;
                            // leaving listen-only mode stays silent
                            if (r_listen) begin
                                n_listen = 1'b0;
                            end else begin
                                put_five = ~i_cmd.bc;
                            end
                        end
                        sdr_pkg::CLS_DIAG_REG: begin
                            put_five = 1'b1;
                            use_fc   = 1'b0;
                            value    = 16'h0000;
                        end
                        sdr_pkg::CLS_LISTEN: begin
                            n_listen           = 1'b1;
                            n_out.event_action = sdr_pkg::EVA_PUSH;
                            n_out.event_code   = sdr_pkg::EV_ENTER_LO;
                        end
                        sdr_pkg::CLS_CLEAR: begin
                            clear_all          = 1'b1;
                            n_out.event_action = sdr_pkg::EVA_CLR_CNT;
                            put_five           = ~i_cmd.bc;
                        end
                        sdr_pkg::CLS_READ: begin
                            put_five = 1'b1;
                            use_fc   = 1'b0;
                            value    = cnt_value;
                        end
                        sdr_pkg::CLS_CLR_OVR: begin
                            put_five  = 1'b1;
                            n_ovr_cnt = 16'h0000;
                        end
                        default: begin
                            put_five = 1'b0;
                        end
                    endcase
                end
            end
            sdr_pkg::ACT_BUS_MSG: begin
                n_bus_cnt = r_bus_cnt + 16'd1;
            end
            sdr_pkg::ACT_COMM_ERR: begin
                n_comm_cnt         = r_comm_cnt + 16'd1;
                n_out.event_action = sdr_pkg::EVA_PUSH;
                n_out.event_code   = sdr_pkg::EV_RX_COMM | lo_mark;
            end
            sdr_pkg::ACT_SLV_MSG: begin
                n_slv_cnt = r_slv_cnt + 16'd1;
            end
            sdr_pkg::ACT_OVERRUN: begin
                n_ovr_cnt          = r_ovr_cnt + 16'd1;
                n_comm_cnt         = r_comm_cnt + 16'd1;
                n_out.event_action = sdr_pkg::EVA_PUSH;
                n_out.event_code   = sdr_pkg::EV_RX_OVR | lo_mark;
            end
            sdr_pkg::ACT_RESULT: begin
                if (i_cmd.was_exc) begin
                    n_exc_cnt = r_exc_cnt + 16'd1;
                end else if (!i_cmd.responded) begin
                    n_nr_cnt = r_nr_cnt + 16'd1;
                end
            end
            sdr_pkg::ACT_RESET: begin
                clear_all = 1'b1;
                n_listen  = 1'b0;
            end
            default: begin
                clear_all = 1'b0;
            end
        endcase

        if (clear_all) begin
            n_bus_cnt  = 16'h0000;
            n_comm_cnt = 16'h0000;
            n_exc_cnt  = 16'h0000;
            n_slv_cnt  = 16'h0000;
            n_nr_cnt   = 16'h0000;
            n_ovr_cnt  = 16'h0000;
        end

        // broadcasts never get a reply, exceptions included
        if (put_five) begin
            n_out.resp_len   = sdr_pkg::LEN_NORMAL;
            n_out.resp_byte0 = use_fc ? i_cmd.fc : sdr_pkg::FC_DIAG;
            n_out.resp_byte1 = i_cmd.sf[15:8];
            n_out.resp_byte2 = i_cmd.sf[7:0];
            n_out.resp_byte3 = value[15:8];
            n_out.resp_byte4 = value[7:0];
        end else if (put_exc && !i_cmd.bc) begin
            n_out.resp_len   = sdr_pkg::LEN_EXC;
            n_out.resp_byte0 = sdr_pkg::FC_DIAG_EXC;
            n_out.resp_byte1 = exc_code;
        end
        n_out.listen_only_now = n_listen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_cnt   <= '0;
            r_comm_cnt  <= '0;
            r_exc_cnt   <= '0;
            r_slv_cnt   <= '0;
            r_nr_cnt    <= '0;
            r_ovr_cnt   <= '0;
            r_listen    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_bus_cnt   <= n_bus_cnt;
                r_comm_cnt  <= n_comm_cnt;
                r_exc_cnt   <= n_exc_cnt;
                r_slv_cnt   <= n_slv_cnt;
                r_nr_cnt    <= n_nr_cnt;
                r_ovr_cnt   <= n_ovr_cnt;
                r_listen    <= n_listen;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== sv/serial_diagnostics_responder.sv =====
`timescale 1ns / 1ps

// Diagnostics responder for serial-line function 0x08. Takes one item per
// clock while o_ready is high: requests and bookkeeping events are decoded
// on entry, wait in a short queue (QUEUE_DEPTH entries) and are executed
// one per cycle unless the output stalls, against the six 16-bit counters
// and the listen-only flag, each giving exactly one result item. An item
// is registered in the queue, then in the output register when executed.
// The execute stage and output register set the rate of one item per cycle;
// o_ready drops only when the queue is full as the output side is stalled.
module serial_diagnostics_responder #(
    parameter int unsigned QUEUE_DEPTH = sdr_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sdr_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output sdr_pkg::t_out o_item
);

    sdr_pkg::t_cmd dec_cmd;
    sdr_pkg::t_cmd q_cmd;
    logic          q_full;
    logic          q_empty;
    logic          q_pop;

    assign o_ready = ~q_full;

    sdr_front u_front (
        .i_item (i_item),
        .o_cmd  (dec_cmd)
    );

    sdr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_cmd   (dec_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    sdr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (~q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int unsigned RANDOM_ITEMS = 1400;
    localparam int unsigned TAIL_ITEMS   = 200;
    localparam int unsigned DRAIN_AT     = 400;
    localparam int unsigned HOLD_AT      = 800;
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned SETTLE       = 12;
    localparam int unsigned MAX_REPORTS  = 10;
    // action code with no meaning, ignored by the block
    localparam logic [2:0]  ACT_UNUSED   = 3'd7;

    class diag_scoreboard;
        logic [15:0] bus_cnt    = '0;
        logic [15:0] comm_cnt   = '0;
        logic [15:0] exc_cnt    = '0;
        logic [15:0] slave_cnt  = '0;
        logic [15:0] noresp_cnt = '0;
        logic [15:0] ovr_cnt    = '0;
        logic        listen_only = 1'b0;
        sdr_pkg::t_out expected_q[$];
        int unsigned items_seen     = 0;
        int unsigned checked        = 0;
        int unsigned mismatches     = 0;
        int unsigned exc_seen       = 0;
        int unsigned count_reads    = 0;
        int unsigned listen_entries = 0;

        function void clear_counts();
            bus_cnt    = '0;
            comm_cnt   = '0;
            exc_cnt    = '0;
            slave_cnt  = '0;
            noresp_cnt = '0;
            ovr_cnt    = '0;
        endfunction

        // broadcasts never get an answer, not even an exception
        function sdr_pkg::t_out exc_resp(logic [7:0] code, logic bc);
            sdr_pkg::t_out r;
            r = '0;
            if (!bc) begin
                r.resp_len   = sdr_pkg::LEN_EXC;
                r.resp_byte0 = sdr_pkg::FC_DIAG_EXC;
                r.resp_byte1 = code;
            end
            return r;
        endfunction

        function sdr_pkg::t_out normal_resp(logic [7:0] b0, logic [15:0] sf,
                                            logic [15:0] v);
            sdr_pkg::t_out r;
            r = '0;
            r.resp_len   = sdr_pkg::LEN_NORMAL;
            r.resp_byte0 = b0;
            r.resp_byte1 = sf[15:8];
            r.resp_byte2 = sf[7:0];
            r.resp_byte3 = v[15:8];
            r.resp_byte4 = v[7:0];
            return r;
        endfunction

        function sdr_pkg::t_out respond(sdr_pkg::t_in x);
            sdr_pkg::t_out r;
            logic [7:0]    lo_code;
            logic [15:0]   sf;
            logic [15:0]   v;
            logic          bc;
            r       = '0;
            lo_code = listen_only ? sdr_pkg::EV_LISTEN : 8'h00;
            sf      = x.sub_func;
            bc      = x.broadcast;
            case (x.action)
                sdr_pkg::ACT_REQUEST: begin
                    if (x.short_request) begin
                        if (!listen_only) r = exc_resp(sdr_pkg::EXC_ILL_VALUE, bc);
                    end else if (listen_only && sf != sdr_pkg::SF_RESTART) begin
                        // drop: only a restart is heard in listen-only mode
                    end else if (bc && sf != sdr_pkg::SF_RESTART &&
                                 sf != sdr_pkg::SF_LISTEN && sf != sdr_pkg::SF_CLEAR) begin
                        // drop: broadcast of a sub-function that is not executed
                    end else begin
                        case (sf)
                            sdr_pkg::SF_ECHO, sdr_pkg::SF_DELIM:
                                r = normal_resp(x.request_fc, sf, x.data_word);
                            sdr_pkg::SF_RESTART: begin
                                if (x.data_word != '0 &&
                                    x.data_word != sdr_pkg::STOP_ON_ERROR) begin
                                    r = exc_resp(sdr_pkg::EXC_ILL_VALUE, bc);
                                end else begin
                                    clear_counts();
                                    if (listen_only) listen_only = 1'b0;
                                    else if (!bc) r = normal_resp(x.request_fc, sf,
                                                                  x.data_word);
                                    r.event_action =
                                        (x.data_word == sdr_pkg::STOP_ON_ERROR) ?
                                        sdr_pkg::EVA_RESTART_C : sdr_pkg::EVA_RESTART;
                                end
                            end
                            sdr_pkg::SF_DIAG_REG, sdr_pkg::SF_LISTEN, sdr_pkg::SF_CLEAR,
                            sdr_pkg::SF_BUS_CNT, sdr_pkg::SF_COMM_CNT, sdr_pkg::SF_EXC_CNT,
                            sdr_pkg::SF_SLV_CNT, sdr_pkg::SF_NR_CNT, sdr_pkg::SF_NAK_CNT,
                            sdr_pkg::SF_BUSY_CNT, sdr_pkg::SF_OVR_CNT,
                            sdr_pkg::SF_CLR_OVR: begin
                                if (x.data_word != '0) begin
                                    r = exc_resp(sdr_pkg::EXC_ILL_VALUE, bc);
                                end else begin
                                    case (sf)
                                        sdr_pkg::SF_DIAG_REG:
                                            r = normal_resp(sdr_pkg::FC_DIAG, sf, '0);
                                        sdr_pkg::SF_LISTEN: begin
                                            listen_only    = 1'b1;
                                            r.event_action = sdr_pkg::EVA_PUSH;
                                            r.event_code   = sdr_pkg::EV_ENTER_LO;
                                            listen_entries++;
                                        end
                                        sdr_pkg::SF_CLEAR: begin
                                            clear_counts();
                                            if (!bc) r = normal_resp(x.request_fc, sf, '0);
                                            r.event_action = sdr_pkg::EVA_CLR_CNT;
                                        end
                                        sdr_pkg::SF_CLR_OVR: begin
                                            ovr_cnt = '0;
                                            r = normal_resp(x.request_fc, sf, '0);
                                        end
                                        default: begin
                                            case (sf)
                                                sdr_pkg::SF_BUS_CNT:  v = bus_cnt;
                                                sdr_pkg::SF_COMM_CNT: v = comm_cnt;
                                                sdr_pkg::SF_EXC_CNT:  v = exc_cnt;
                                                sdr_pkg::SF_SLV_CNT:  v = slave_cnt;
                                                sdr_pkg::SF_NR_CNT:   v = noresp_cnt;
                                                sdr_pkg::SF_OVR_CNT:  v = ovr_cnt;
                                                default:              v = '0;
                                            endcase
                                            r = normal_resp(sdr_pkg::FC_DIAG, sf, v);
                                            count_reads++;
                                        end
                                    endcase
                                end
                            end
                            default: r = exc_resp(sdr_pkg::EXC_ILL_FUNC, bc);
                        endcase
                    end
                end
                sdr_pkg::ACT_BUS_MSG: bus_cnt += 16'd1;
                sdr_pkg::ACT_COMM_ERR: begin
                    comm_cnt += 16'd1;
                    r.event_action = sdr_pkg::EVA_PUSH;
                    r.event_code   = sdr_pkg::EV_RX_COMM | lo_code;
                end
                sdr_pkg::ACT_SLV_MSG: slave_cnt += 16'd1;
                sdr_pkg::ACT_OVERRUN: begin
                    // an overrun also counts as a comm error
                    ovr_cnt  += 16'd1;
                    comm_cnt += 16'd1;
                    r.event_action = sdr_pkg::EVA_PUSH;
                    r.event_code   = sdr_pkg::EV_RX_OVR | lo_code;
                end
                sdr_pkg::ACT_RESULT: begin
                    if (x.was_exception) exc_cnt += 16'd1;
                    else if (!x.responded) noresp_cnt += 16'd1;
                end
                sdr_pkg::ACT_RESET: begin
                    clear_counts();
                    listen_only = 1'b0;
                end
                default: ;
            endcase
            r.listen_only_now = listen_only;
            if (r.resp_len == sdr_pkg::LEN_EXC) exc_seen++;
            return r;
        endfunction

        function void note_item(sdr_pkg::t_in x);
            items_seen++;
            expected_q.push_back(respond(x));
        endfunction

        function string show(sdr_pkg::t_out r);
            return $sformatf("len %0d bytes %h %h %h %h %h log %0d/%h lo %b",
                             r.resp_len, r.resp_byte0, r.resp_byte1, r.resp_byte2,
                             r.resp_byte3, r.resp_byte4, r.event_action, r.event_code,
                             r.listen_only_now);
        endfunction

        function void check_result(sdr_pkg::t_out got);
            sdr_pkg::t_out want;
            string         bad;
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with nothing pending: %s", $time, show(got));
                return;
            end
            want = expected_q.pop_front();
            bad  = "";
            if (got.resp_len        !== want.resp_len)        bad = {bad, " resp_len"};
            if (got.resp_byte0      !== want.resp_byte0)      bad = {bad, " resp_byte0"};
            if (got.resp_byte1      !== want.resp_byte1)      bad = {bad, " resp_byte1"};
            if (got.resp_byte2      !== want.resp_byte2)      bad = {bad, " resp_byte2"};
            if (got.resp_byte3      !== want.resp_byte3)      bad = {bad, " resp_byte3"};
            if (got.resp_byte4      !== want.resp_byte4)      bad = {bad, " resp_byte4"};
            if (got.event_action    !== want.event_action)    bad = {bad, " event_action"};
            if (got.event_code      !== want.event_code)      bad = {bad, " event_code"};
            if (got.listen_only_now !== want.listen_only_now) bad = {bad, " listen_only_now"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result %0d wrong in%s\n  expected %s\n  actual   %s",
                             $time, checked, bad, show(want), show(got));
            end
        endfunction

        function int unsigned outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    sdr_pkg::t_in  i_item;
    logic          o_valid;
    logic          i_ready;
    sdr_pkg::t_out o_item;

    bit tail_phase = 1'b0;
    bit hold_off   = 1'b0;

    diag_scoreboard sb = new();

    serial_diagnostics_responder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_item(i_item);
            if (o_valid && i_ready) sb.check_result(o_item);
        end
    end

    initial begin
        int unsigned stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) stalled = 0;
            else stalled++;
        end
        $display("No item moved for %0d cycles, %0d results still pending",
                 STALL_LIMIT, sb.outstanding());
        $display("== FAIL ==");
        $finish;
    end

    // output side: random stalls, one long hold-off on request, none in the tail
    initial begin
        i_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off) begin
                hold_off = 1'b0;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!tail_phase && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic sdr_pkg::t_in diag_item(logic [2:0] act, logic [15:0] sf = '0,
                                               logic [15:0] data = '0,
                                               logic [7:0] fc = sdr_pkg::FC_DIAG,
                                               logic bc = 1'b0, logic short_req = 1'b0,
                                               logic resp = 1'b0, logic was_exc = 1'b0);
        sdr_pkg::t_in x;
        x.action        = act;
        x.request_fc    = fc;
        x.short_request = short_req;
        x.sub_func      = sf;
        x.data_word     = data;
        x.broadcast     = bc;
        x.responded     = resp;
        x.was_exception = was_exc;
        return x;
    endfunction

    // mostly well-formed requests and events with random content, some noise
    function automatic sdr_pkg::t_in random_item();
        sdr_pkg::t_in x;
        int           pick;
        pick = $urandom_range(0, 99);
        if      (pick < 55) x.action = sdr_pkg::ACT_REQUEST;
        else if (pick < 63) x.action = sdr_pkg::ACT_BUS_MSG;
        else if (pick < 70) x.action = sdr_pkg::ACT_COMM_ERR;
        else if (pick < 78) x.action = sdr_pkg::ACT_SLV_MSG;
        else if (pick < 84) x.action = sdr_pkg::ACT_OVERRUN;
        else if (pick < 97) x.action = sdr_pkg::ACT_RESULT;
        else if (pick < 99) x.action = sdr_pkg::ACT_RESET;
        else                x.action = ACT_UNUSED;
        x.request_fc    = ($urandom_range(0, 2) == 0) ? sdr_pkg::FC_DIAG :
                                                        8'($urandom_range(0, 255));
        x.short_request = ($urandom_range(0, 40) == 0);
        x.broadcast     = ($urandom_range(0, 9) == 0);
        x.responded     = 1'($urandom_range(0, 1));
        x.was_exception = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1:    x.sub_func = sdr_pkg::SF_ECHO;
            2:       x.sub_func = sdr_pkg::SF_DELIM;
            3, 4:    x.sub_func = sdr_pkg::SF_RESTART;
            5:       x.sub_func = sdr_pkg::SF_DIAG_REG;
            6:       x.sub_func = sdr_pkg::SF_LISTEN;
            7:       x.sub_func = sdr_pkg::SF_CLEAR;
            16:      x.sub_func = sdr_pkg::SF_CLR_OVR;
            17:      x.sub_func = 16'($urandom_range(0, 31));
            18, 19:  x.sub_func = 16'($urandom_range(0, 65535));
            default: x.sub_func = sdr_pkg::SF_BUS_CNT + 16'(pick - 8);
        endcase
        pick = $urandom_range(0, 9);
        if (x.sub_func == sdr_pkg::SF_ECHO || x.sub_func == sdr_pkg::SF_DELIM)
            x.data_word = 16'($urandom_range(0, 65535));
        else if (x.sub_func == sdr_pkg::SF_RESTART && pick < 8)
            x.data_word = (pick < 4) ? 16'h0000 : sdr_pkg::STOP_ON_ERROR;
        else if (pick < 8)
            x.data_word = '0;
        else
            x.data_word = 16'($urandom_range(0, 65535));
        return x;
    endfunction

    task automatic offer_item(input sdr_pkg::t_in x, input int unsigned gap);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= x;
        do @(posedge i_clk); while (!o_ready);
    endtask

    initial begin
        int unsigned gap;
        int unsigned directed;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes, every event, every counter read
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_ECHO, 16'hFFFF, 8'hFF), 0);
        offer_item(diag_item(sdr_pkg::ACT_BUS_MSG), 0);
        offer_item(diag_item(sdr_pkg::ACT_COMM_ERR), 0);
        offer_item(diag_item(sdr_pkg::ACT_SLV_MSG), 0);
        offer_item(diag_item(sdr_pkg::ACT_OVERRUN), 0);
        offer_item(diag_item(sdr_pkg::ACT_RESULT, '0, '0, sdr_pkg::FC_DIAG,
                             1'b0, 1'b0, 1'b1, 1'b1), 0);
        offer_item(diag_item(sdr_pkg::ACT_RESULT), 0);
        for (int k = 0; k <= sdr_pkg::SF_OVR_CNT - sdr_pkg::SF_BUS_CNT; k++)
            offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_BUS_CNT + 16'(k)), 0);
        // exceptions: bad data word, unknown sub-function, short request
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_DIAG_REG, 16'h0001), 0);
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, 16'hFFFF, '0, 8'h00), 0);
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_ECHO, 16'h1234,
                             sdr_pkg::FC_DIAG, 1'b0, 1'b1), 0);
        // broadcasts: one executed silently, one dropped
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_CLEAR, '0,
                             sdr_pkg::FC_DIAG, 1'b1), 0);
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_ECHO, 16'h5A5A,
                             sdr_pkg::FC_DIAG, 1'b1), 0);
        // listen-only mode, then out again through restarts
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_LISTEN, '0, 8'h00), 0);
        offer_item(diag_item(sdr_pkg::ACT_OVERRUN), 0);
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_RESTART, 16'h00FF), 0);
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_RESTART,
                             sdr_pkg::STOP_ON_ERROR), 0);
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_RESTART, '0), 0);
        offer_item(diag_item(sdr_pkg::ACT_REQUEST, sdr_pkg::SF_CLR_OVR), 0);
        offer_item(diag_item(sdr_pkg::ACT_RESET), 0);
        offer_item(diag_item(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF,
                             1'b1, 1'b1, 1'b1, 1'b1), 0);
        directed = sb.items_seen;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
            if (n == DRAIN_AT) begin
                // hold the input until every pending result is out
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.outstanding() != 0) @(posedge i_clk);
            end
            if (n == HOLD_AT) hold_off = 1'b1;
            gap = (!tail_phase && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
            offer_item(random_item(), gap);
        end
        i_valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Sent %0d items (%0d directed), checked %0d results, %0d mismatches.",
                 sb.items_seen, directed, sb.checked, sb.mismatches);
        $display("Covered %0d exceptions, %0d counter reads, %0d entries to listen-only mode.",
                 sb.exc_seen, sb.count_reads, sb.listen_entries);
        if (sb.outstanding() != 0)
            $display("%0d expected results never arrived", sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== serial_diagnostics_responder.f =====
sv/sdr_pkg.sv
sv/sdr_front.sv
sv/sdr_queue.sv
sv/sdr_back.sv
sv/serial_diagnostics_responder.sv
tb/sv/tb.sv
